// ===== src/sbd_pkg.sv =====
// Shared types and constants for the screen block differ.
// Used by every module of the block but sbd_ram; depends on nothing else.
`timescale 1ns / 1ps
package sbd_pkg;
  localparam int BLK_LOG   = 4;
  localparam int BLK_SIZE  = 1 << BLK_LOG;
  localparam int COORD_W   = 11;
  localparam int DIM_W     = 12;
  localparam int MAP_W     = COORD_W - BLK_LOG;
  localparam int CNT_W     = MAP_W + 1;
  localparam int MAP_DEPTH = 1 << (2 * MAP_W);
  localparam int LB_DEPTH  = 1 << MAP_W;
  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(2048);

  localparam logic [1:0] ST_RECT = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  typedef struct packed {
    logic        action;
    logic [31:0] prev_pixel;
    logic [31:0] curr_pixel;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [DIM_W-1:0]   rect_w;
    logic [DIM_W-1:0]   rect_h;
  } result_t;

  typedef struct packed {
    logic             fetch;
    logic             incomplete;
    logic             diff;
    logic             first;
    logic             blk_end;
    logic             frame_end;
    logic [MAP_W-1:0] bx;
    logic [MAP_W-1:0] by;
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             mode;
    logic             restart;
  } cfg_t;
endpackage

// ===== src/sbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps
module sbd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/sbd_front.sv =====
// Front end: accepts words, tracks the raster position and classifies each word.
// Depends on sbd_pkg.
`timescale 1ns / 1ps
module sbd_front (
  input  logic          clk,
  input  logic          rst,
  input  sbd_pkg::cfg_t cfg,
  input  logic          push,
  input  sbd_pkg::item_t item,
  input  logic          q_full,
  output logic          q_push,
  output sbd_pkg::op_t  op,
  output logic          full
);
  import sbd_pkg::*;

  logic [COORD_W-1:0] pixel_col, pixel_row, col_eff, row_eff;
  logic               frame_done;
  logic               col_last, row_last, diff;
  logic [31:0]        delta;

  assign full    = q_full;
  assign q_push  = push && !q_full;
  assign col_eff = frame_done ? '0 : pixel_col;
  assign row_eff = frame_done ? '0 : pixel_row;
  assign col_last = ({1'b0, col_eff} + DIM_W'(1)) >= cfg.width;
  assign row_last = ({1'b0, row_eff} + DIM_W'(1)) >= cfg.height;
  assign delta = item.prev_pixel ^ item.curr_pixel;
  assign diff  = cfg.mode ? (|delta) : (|delta[15:0]);

  always_comb begin
    op.fetch      = item.action;
    op.incomplete = !frame_done;
    op.diff       = diff;
    op.first      = (col_eff[BLK_LOG-1:0] == '0) && (row_eff[BLK_LOG-1:0] == '0);
    op.blk_end    = ((&col_eff[BLK_LOG-1:0]) || col_last) &&
                    ((&row_eff[BLK_LOG-1:0]) || row_last);
    op.frame_end  = col_last && row_last;
    op.bx         = col_eff[COORD_W-1:BLK_LOG];
    op.by         = row_eff[COORD_W-1:BLK_LOG];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      pixel_col  <= '0;
      pixel_row  <= '0;
      frame_done <= 1'b0;
    end else if (q_push && !item.action) begin
      frame_done <= col_last && row_last;
      if (col_last) begin
        pixel_col <= '0;
        pixel_row <= row_last ? '0 : row_eff + COORD_W'(1);
      end else begin
        pixel_col <= col_eff + COORD_W'(1);
        pixel_row <= row_eff;
      end
    end
  end
endmodule

// ===== src/sbd_opq.sv =====
// Two-entry queue of classified words between the front and back ends.
// Depends on sbd_pkg.
`timescale 1ns / 1ps
module sbd_opq (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  sbd_pkg::op_t wdata,
  output logic         full,
  input  logic         rd,
  output sbd_pkg::op_t rdata,
  output logic         empty
);
  import sbd_pkg::*;

  op_t        slots [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (wr) wptr <= !wptr;
      if (rd) rptr <= !rptr;
      count <= count + 2'(wr) - 2'(rd);
    end
  end
endmodule

// ===== src/sbd_back.sv =====
// Back end: marks blocks from pixel words and merges marks into rectangles on fetch.
// Depends on sbd_pkg and sbd_ram.
`timescale 1ns / 1ps
module sbd_back (
  input  logic             clk,
  input  logic             rst,
  input  sbd_pkg::cfg_t    cfg,
  input  sbd_pkg::op_t     q_op,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output sbd_pkg::result_t result
);
  import sbd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_SCHK = 4'd2;
  localparam logic [3:0] S_RGT  = 4'd3;
  localparam logic [3:0] S_RCHK = 4'd4;
  localparam logic [3:0] S_DN   = 4'd5;
  localparam logic [3:0] S_DRD  = 4'd6;
  localparam logic [3:0] S_DCHK = 4'd7;
  localparam logic [3:0] S_DCLR = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  logic [3:0]         state, state_next;
  logic [MAP_W-1:0]   cx, cx_next, bx, bx_next, by, by_next, idx, idx_next;
  logic [CNT_W-1:0]   cy, cy_next, runw, runw_next, runh, runh_next;
  logic [1:0]         res_status, res_status_next;
  logic [CNT_W-1:0]   bw, bh, right_col, down_row, col_i;
  logic [DIM_W:0]     bw_sum, bh_sum;

  // Pixel marking stage.
  logic               p_valid, byp, lb_q, p_old, p_new;
  logic               byp_data;
  op_t                p_op;

  logic               dm_q, f_we;
  logic [2*MAP_W-1:0] f_waddr, f_raddr;
  logic               dm_we, dm_wdata;
  logic [2*MAP_W-1:0] dm_waddr;

  logic               out_valid, slot_free, load;
  result_t            res;
  logic [COORD_W-1:0] x, y;
  logic [DIM_W-1:0]   w_full, h_full, room_w, room_h;

  assign bw_sum = {1'b0, cfg.width} + (DIM_W+1)'(BLK_SIZE - 1);
  assign bh_sum = {1'b0, cfg.height} + (DIM_W+1)'(BLK_SIZE - 1);
  assign bw = CNT_W'(bw_sum >> BLK_LOG);
  assign bh = CNT_W'(bh_sum >> BLK_LOG);
  assign right_col = {1'b0, bx} + runw;
  assign down_row  = {1'b0, by} + runh;
  assign col_i     = {1'b0, bx} + {1'b0, idx};

  assign q_pop = (state == S_IDLE) && !q_empty;

  // The first pixel of a block overwrites its mark; later ones accumulate.
  assign p_old = byp ? byp_data : lb_q;
  assign p_new = p_op.first ? p_op.diff : (p_old | p_op.diff);

  sbd_ram #(.WIDTH(1), .DEPTH(LB_DEPTH)) u_line (
    .clk   (clk),
    .we    (p_valid),
    .waddr (p_op.bx),
    .wdata (p_new),
    .raddr (q_op.bx),
    .rdata (lb_q)
  );

  assign dm_we    = f_we || (p_valid && p_op.blk_end);
  assign dm_waddr = f_we ? f_waddr : {p_op.by, p_op.bx};
  assign dm_wdata = f_we ? 1'b0 : p_new;

  sbd_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .raddr (f_raddr),
    .rdata (dm_q)
  );

  always_ff @(posedge clk) begin
    p_op     <= q_op;
    byp      <= p_valid && (p_op.bx == q_op.bx);
    byp_data <= p_new;
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= q_pop && !q_op.fetch;
    end
  end

  always_comb begin
    state_next      = state;
    cx_next         = cx;
    cy_next         = cy;
    bx_next         = bx;
    by_next         = by;
    runw_next       = runw;
    runh_next       = runh;
    idx_next        = idx;
    res_status_next = res_status;
    f_we            = 1'b0;
    f_waddr         = {by, bx};
    f_raddr         = {cy[MAP_W-1:0], cx};
    load            = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_pop && q_op.fetch) begin
          if (q_op.incomplete) begin
            res_status_next = ST_BUSY;
            state_next      = S_EMIT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cy >= bh) begin
          res_status_next = ST_NONE;
          state_next      = S_EMIT;
        end else begin
          state_next = S_SCHK;
        end
      end
      S_SCHK: begin
        if (({1'b0, cx} + CNT_W'(1)) == bw) begin
          cx_next = '0;
          cy_next = cy + CNT_W'(1);
        end else begin
          cx_next = cx + MAP_W'(1);
        end
        if (dm_q) begin
          f_we      = 1'b1;
          f_waddr   = {cy[MAP_W-1:0], cx};
          bx_next   = cx;
          by_next   = cy[MAP_W-1:0];
          runw_next = CNT_W'(1);
          state_next = S_RGT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_RGT: begin
        f_raddr = {by, right_col[MAP_W-1:0]};
        if (right_col < bw) begin
          state_next = S_RCHK;
        end else begin
          runh_next  = CNT_W'(1);
          state_next = S_DN;
        end
      end
      S_RCHK: begin
        if (dm_q) begin
          f_we       = 1'b1;
          f_waddr    = {by, right_col[MAP_W-1:0]};
          runw_next  = runw + CNT_W'(1);
          state_next = S_RGT;
        end else begin
          runh_next  = CNT_W'(1);
          state_next = S_DN;
        end
      end
      S_DN: begin
        idx_next = '0;
        if (down_row < bh) begin
          state_next = S_DRD;
        end else begin
          res_status_next = ST_RECT;
          state_next      = S_EMIT;
        end
      end
      S_DRD: begin
        f_raddr    = {down_row[MAP_W-1:0], col_i[MAP_W-1:0]};
        state_next = S_DCHK;
      end
      S_DCHK: begin
        if (!dm_q) begin
          res_status_next = ST_RECT;
          state_next      = S_EMIT;
        end else if (({1'b0, idx} + CNT_W'(1)) == runw) begin
          idx_next   = '0;
          state_next = S_DCLR;
        end else begin
          idx_next   = idx + MAP_W'(1);
          state_next = S_DRD;
        end
      end
      S_DCLR: begin
        // The whole row under the run is dirty: clear it one block a cycle.
        f_we    = 1'b1;
        f_waddr = {down_row[MAP_W-1:0], col_i[MAP_W-1:0]};
        if (({1'b0, idx} + CNT_W'(1)) == runw) begin
          runh_next  = runh + CNT_W'(1);
          state_next = S_DN;
        end else begin
          idx_next = idx + MAP_W'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign x      = {bx, {BLK_LOG{1'b0}}};
  assign y      = {by, {BLK_LOG{1'b0}}};
  assign w_full = {runw, {BLK_LOG{1'b0}}};
  assign h_full = {runh, {BLK_LOG{1'b0}}};
  assign room_w = cfg.width - {1'b0, x};
  assign room_h = cfg.height - {1'b0, y};

  always_comb begin
    res = '0;
    res.status = res_status;
    if (res_status == ST_RECT) begin
      res.rect_x = x;
      res.rect_y = y;
      res.rect_w = (w_full > room_w) ? room_w : w_full;
      res.rect_h = (h_full > room_h) ? room_h : h_full;
    end
  end

  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res;
    end
    bx         <= bx_next;
    by         <= by_next;
    runw       <= runw_next;
    runh       <= runh_next;
    idx        <= idx_next;
    res_status <= res_status_next;
    if (rst) begin
      state     <= S_IDLE;
      cx        <= '0;
      cy        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= load || (out_valid && !pop);
      if (cfg.restart || (p_valid && p_op.frame_end)) begin
        cx <= '0;
        cy <= '0;
      end else begin
        cx <= cx_next;
        cy <= cy_next;
      end
    end
  end
endmodule

// ===== src/screen_block_diff_dirty_rects.sv =====
// Screen block differ: pixel words are taken one per cycle while full is low and are
// marked in the block map through the queue and the pixel marking stage; a fetch probes
// blocks in the map (one read port, registered data), clears the row blocks it merges and emits.
// Synchronous reset clears position, frame and cursor state; the block map needs no
// clearing since every on-screen block is rewritten by each frame before it is read.
// Depends on sbd_pkg, sbd_front, sbd_opq, sbd_back and sbd_ram.
`timescale 1ns / 1ps
module screen_block_diff_dirty_rects (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  sbd_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output sbd_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sbd_pkg::*;

  logic [DIM_W-1:0] frame_width, frame_height;
  logic             pixel_mode;
  logic             wr, reg_hit;
  logic [1:0]       reg_idx;
  cfg_t             cfg;
  op_t              f_op, b_op;
  logic             q_push, q_full, q_pop, q_empty;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > MAX_DIM) r = MAX_DIM;
    return r;
  endfunction

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite && pready;
  assign reg_hit = (reg_idx == REG_WIDTH) || (reg_idx == REG_HEIGHT) ||
                   (reg_idx == REG_MODE);

  always_comb begin
    cfg.width   = frame_width;
    cfg.height  = frame_height;
    cfg.mode    = pixel_mode;
    cfg.restart = wr && reg_hit;
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_WIDTH:  prdata = 32'(frame_width);
      REG_HEIGHT: prdata = 32'(frame_height);
      REG_MODE:   prdata = 32'(pixel_mode);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(1024);
      frame_height <= DIM_W'(768);
      pixel_mode   <= 1'b1;
    end else if (wr) begin
      unique case (reg_idx)
        REG_WIDTH:  frame_width  <= clamp_dim(pwdata[DIM_W-1:0]);
        REG_HEIGHT: frame_height <= clamp_dim(pwdata[DIM_W-1:0]);
        REG_MODE:   pixel_mode   <= pwdata[0];
        default:    ;
      endcase
    end
  end

  sbd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .op     (f_op),
    .full   (full)
  );

  sbd_opq u_opq (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (f_op),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (b_op),
    .empty (q_empty)
  );

  sbd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_op    (b_op),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );
endmodule

// ===== tb/sbd_checker.sv =====
// Checker for the screen block differ: watches the item, result and register channels,
// predicts every result from its own copy of the block map and compares in order.
// Depends on sbd_pkg only.
`timescale 1ns / 1ps
module sbd_checker
  import sbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    full,
  input  item_t   item,
  input  logic    empty,
  input  logic    pop,
  input  result_t result,
  input  logic    psel,
  input  logic    penable,
  input  logic    pwrite,
  input  logic    pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int      fails,
  output int      pending,
  output logic    map_drained
);
  localparam int BS = 16;
  localparam int MAXD = 2048;
  localparam int MCOLS = MAXD / BS + 1;
  localparam int MROWS = MAXD / BS + 1;

  bit dirty[MROWS*MCOLS];
  int frame_w, frame_h, col, row, cursor;
  bit mode32, complete;
  result_t rect_q[$];

  function automatic int clamp_dim(int v);
    if (v == 0) return 1;
    if (v > MAXD) return MAXD;
    return v;
  endfunction

  function automatic void restart_frame();
    foreach (dirty[i]) dirty[i] = 0;
    col = 0;
    row = 0;
    complete = 0;
    cursor = 0;
  endfunction

  function automatic void mark_pixel(logic [31:0] prv, logic [31:0] cur);
    logic [31:0] mask;
    bit d;
    int idx;
    mask = mode32 ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    d = ((prv ^ cur) & mask) != 0;
    if (complete) begin
      complete = 0;
      cursor = 0;
      col = 0;
      row = 0;
    end
    idx = (row / BS) * MCOLS + col / BS;
    // The top-left pixel of a block overwrites its mark; the rest only set it.
    if (col % BS == 0 && row % BS == 0) dirty[idx] = d;
    else dirty[idx] = dirty[idx] | d;
    if (col + 1 >= frame_w) begin
      col = 0;
      if (row + 1 >= frame_h) begin
        row = 0;
        complete = 1;
        cursor = 0;
      end else begin
        row++;
      end
    end else begin
      col++;
    end
  endfunction

  function automatic result_t next_rect();
    result_t r;
    int bw, bh, total, c, bx, by, runw, runh, base, w, h;
    bit whole;
    r = '0;
    if (!complete) begin
      r.status = ST_BUSY;
      return r;
    end
    bw = (frame_w + BS - 1) / BS;
    bh = (frame_h + BS - 1) / BS;
    total = bw * bh;
    for (c = cursor; c < total; c++)
      if (dirty[(c / bw) * MCOLS + c % bw]) break;
    if (c >= total) begin
      cursor = total;
      r.status = ST_NONE;
      return r;
    end
    bx = c % bw;
    by = c / bw;
    dirty[by * MCOLS + bx] = 0;
    runw = 1;
    while (bx + runw < bw && dirty[by * MCOLS + bx + runw]) begin
      dirty[by * MCOLS + bx + runw] = 0;
      runw++;
    end
    runh = 1;
    while (by + runh < bh) begin
      base = (by + runh) * MCOLS + bx;
      whole = 1;
      for (int i = 0; i < runw; i++) if (!dirty[base + i]) whole = 0;
      if (!whole) break;
      for (int i = 0; i < runw; i++) dirty[base + i] = 0;
      runh++;
    end
    cursor = c + 1;
    w = runw * BS;
    h = runh * BS;
    if (w > frame_w - bx * BS) w = frame_w - bx * BS;
    if (h > frame_h - by * BS) h = frame_h - by * BS;
    r.status = ST_RECT;
    r.rect_x = COORD_W'(bx * BS);
    r.rect_y = COORD_W'(by * BS);
    r.rect_w = DIM_W'(w);
    r.rect_h = DIM_W'(h);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      frame_w = 1024;
      frame_h = 768;
      mode32 = 1;
      restart_frame();
      rect_q.delete();
      fails = 0;
      map_drained = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[3:2] == REG_WIDTH) begin
          frame_w = clamp_dim(int'(pwdata[11:0]));
          restart_frame();
        end else if (paddr[3:2] == REG_HEIGHT) begin
          frame_h = clamp_dim(int'(pwdata[11:0]));
          restart_frame();
        end else if (paddr[3:2] == REG_MODE) begin
          mode32 = pwdata[0];
          restart_frame();
        end
      end
      if (push && !full) begin
        if (item.action) begin
          want = next_rect();
          map_drained = (want.status == ST_NONE);
          rect_q.push_back(want);
        end else begin
          mark_pixel(item.prev_pixel, item.curr_pixel);
          map_drained = 0;
        end
      end
      if (pop && !empty) begin
        if (rect_q.size() == 0) begin
          $error("result word with nothing expected: status %0d", result.status);
          fails++;
        end else begin
          want = rect_q.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            fails++;
          end
          if (result.rect_x !== want.rect_x) begin
            $error("rect_x: expected %0d, got %0d", want.rect_x, result.rect_x);
            fails++;
          end
          if (result.rect_y !== want.rect_y) begin
            $error("rect_y: expected %0d, got %0d", want.rect_y, result.rect_y);
            fails++;
          end
          if (result.rect_w !== want.rect_w) begin
            $error("rect_w: expected %0d, got %0d", want.rect_w, result.rect_w);
            fails++;
          end
          if (result.rect_h !== want.rect_h) begin
            $error("rect_h: expected %0d, got %0d", want.rect_h, result.rect_h);
            fails++;
          end
        end
      end
    end
    pending = rect_q.size();
  end
endmodule

// ===== tb/screen_block_diff_dirty_rects_tb.sv =====
// Top of the screen block differ testbench: clock, reset, frame and fetch stimulus,
// register writes and the verdict. Depends on sbd_pkg, sbd_checker and the block.
`timescale 1ns / 1ps
module screen_block_diff_dirty_rects_tb;
  import sbd_pkg::*;

  logic clk = 0, rst = 1;
  logic push = 0, pop = 0;
  logic full, empty;
  item_t item = '0;
  result_t result;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  int fails, pending;
  logic map_drained;
  logic hold_req = 0;
  bit mode32 = 1;
  bit quiet = 0;
  int sent = 0;

  always #1 clk = ~clk;

  screen_block_diff_dirty_rects u_dut (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sbd_checker u_chk (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fails, .pending, .map_drained
  );

  // Frame size currently programmed, tracked from the last writes.
  int cur_w = 1024, cur_h = 768;
  always @(posedge clk)
    if (psel && penable && pwrite && pready) begin
      if (paddr[3:2] == REG_WIDTH)
        cur_w <= (pwdata[11:0] == 0) ? 1 : (pwdata[11:0] > 2048) ? 2048 : int'(pwdata[11:0]);
      if (paddr[3:2] == REG_HEIGHT)
        cur_h <= (pwdata[11:0] == 0) ? 1 : (pwdata[11:0] > 2048) ? 2048 : int'(pwdata[11:0]);
    end

  function automatic int u_chk_size();
    return cur_w * cur_h;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random pops, one long hold-off when the sender asks for it.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        pop <= 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end
      pop <= ($urandom_range(0, 3) != 0);
      @(negedge clk);
    end
  end

  // The word is offered from a falling edge and counts as taken at the first
  // rising edge that sees full low.
  task automatic send_word(item_t w);
    int g;
    push <= 1;
    item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    sent++;
    g = quiet ? 0 : pick_gap();
    if (g > 0) begin
      push <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic send_fetch();
    item_t w;
    w.action = 1;
    w.prev_pixel = $urandom;
    w.curr_pixel = $urandom;
    send_word(w);
  endtask

  // pct_diff: chance in percent that a pixel differs in the compared bits.
  task automatic send_pixel(int pct_diff);
    item_t w;
    w.action = 0;
    w.prev_pixel = $urandom;
    w.curr_pixel = w.prev_pixel;
    if ($urandom_range(0, 99) < pct_diff) begin
      if (!mode32 || $urandom_range(0, 1)) w.curr_pixel ^= 32'(1) << $urandom_range(0, 15);
      else w.curr_pixel ^= 32'(1) << $urandom_range(16, 31);
    end else if (!mode32 && $urandom_range(0, 2) == 0) begin
      // Differences in the upper half do not count in 16-bit mode.
      w.curr_pixel ^= {16'($urandom_range(1, 65535)), 16'h0};
    end
    send_word(w);
  endtask

  task automatic wait_idle();
    push <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [11:0] v);
    wait_idle();
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= {20'($urandom), v};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(negedge clk);
    if (idx == REG_MODE) mode32 = v[0];
  endtask

  task automatic set_frame(int w, int h, bit m);
    reg_write(REG_WIDTH, 12'(w));
    reg_write(REG_HEIGHT, 12'(h));
    reg_write(REG_MODE, {11'h0, m});
  endtask

  // A whole frame with stray early fetches, then fetches until the map is drained
  // (or an early stop that leaves marks behind for the next frame to overwrite).
  task automatic run_frame(int npix, int pct_diff, bit drain);
    int n;
    for (int i = 0; i < npix; i++) begin
      send_pixel(pct_diff);
      if ($urandom_range(0, 59) == 0) send_fetch();
    end
    n = 0;
    do begin
      send_fetch();
      n++;
    end while (!map_drained && (drain || n < 3));
    if (drain && $urandom_range(0, 1)) send_fetch();
  endtask

  initial begin
    int w, h, r, pct;
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: fetch after reset, single-pixel frames, field extremes.
    send_fetch();
    set_frame(1, 1, 1);
    send_word('{action: 0, prev_pixel: 32'hFFFF_FFFF, curr_pixel: 32'h0});
    send_fetch();
    send_fetch();
    send_fetch();
    send_word('{action: 0, prev_pixel: 32'h0, curr_pixel: 32'h0});
    send_fetch();
    reg_write(REG_MODE, 12'h0);
    send_word('{action: 0, prev_pixel: 32'hFFFF_0000, curr_pixel: 32'h0});
    send_fetch();
    send_word('{action: 0, prev_pixel: 32'h0000_FFFF, curr_pixel: 32'h0});
    send_fetch();
    send_fetch();
    set_frame(20, 18, 1);
    for (int i = 0; i < 10; i++) send_pixel(50);
    send_fetch();
    reg_write(REG_HEIGHT, 12'h0);
    run_frame(20, 100, 1);

    // Receiver held off while fetches pile up ahead of a complete frame.
    set_frame(24, 16, 1);
    hold_req = 1;
    quiet = 1;
    for (int i = 0; i < 60; i++) send_fetch();
    quiet = 0;
    wait_idle();
    run_frame(24 * 16, 30, 1);

    // Out-of-range sizes: oversize saturates, zero acts as one.
    set_frame(4095, 1, 0);
    for (int i = 0; i < 64; i++) send_pixel(2);
    send_fetch();
    set_frame(0, 0, 1);
    run_frame(1, 100, 1);
    set_frame(17, 17, 1);
    run_frame(17 * 17, 100, 1);

    while (sent < 1750) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        w = $urandom_range(49, 64);
        h = $urandom_range(1, 12);
      end else if (r == 1) begin
        w = $urandom_range(1, 16);
        h = $urandom_range(33, 48);
      end else begin
        w = $urandom_range(1, 32);
        h = $urandom_range(1, 20);
      end
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 1;
        2: pct = 8;
        default: pct = 60;
      endcase
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (r < 6) begin
        set_frame(w, h, $urandom_range(0, 1));
        run_frame(w * h, pct, $urandom_range(0, 5) != 0);
      end else if (r < 8) begin
        // New frame at the same size straight after the previous one.
        run_frame(u_chk_size(), pct, 1);
      end else begin
        // Broken frame: cut short, then a register write restarts it.
        set_frame(w, h, $urandom_range(0, 1));
        for (int i = 0; i < (w * h) / 2; i++) send_pixel(pct);
        send_fetch();
        reg_write(REG_MODE, {11'h0, mode32});
        run_frame(w * h, pct, 1);
      end
    end
    quiet = 0;

    push <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fails == 0) $display("** screen_block_diff_dirty_rects: PASSED **");
    else $display("** screen_block_diff_dirty_rects: FAILED **");
    $finish;
  end

  initial begin
    #4000000;
    $display("** screen_block_diff_dirty_rects: FAILED **");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/sbd_pkg.sv
src/sbd_ram.sv
src/sbd_front.sv
src/sbd_opq.sv
src/sbd_back.sv
src/screen_block_diff_dirty_rects.sv
tb/sbd_checker.sv
tb/screen_block_diff_dirty_rects_tb.sv
